FILE: design/assert_macros.svh
// Assertion macros shared by the URL percent decoder RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define URLPD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define URLPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");
`else
`define URLPD_ASSERT(label, clk, rst_n, prop)
`define URLPD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/urlpd_pkg.sv
// Shared types and constants of the URL percent decoder.
// Depends on nothing; used by every module of the block.
package urlpd_pkg;

	localparam int unsigned MAX_MSG_LEN = 65535;
	localparam logic [15:0] COUNT_CAP =
		(MAX_MSG_LEN > 65535) ? 16'hFFFF : 16'(MAX_MSG_LEN);
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_BAD_HEX = 2'd1,
		STATUS_TRUNC = 2'd2
	} status_t;

	// One classified input byte: an optional data byte then an optional status record.
	typedef struct packed {
		logic has_data;
		logic [7:0] data;
		logic has_status;
		status_t code;
		logic [15:0] length;
	} entry_t;

endpackage

FILE: design/urlpd_front.sv
// Front end of the URL percent decoder: accepts bytes, tracks escapes and faults.
// Depends on urlpd_pkg; feeds classified entries into urlpd_queue.
module urlpd_front (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	output logic byte_stall,
	input logic [7:0] in_byte,
	input logic in_last,
	input logic queue_full,
	output logic push,
	output urlpd_pkg::entry_t push_entry
);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PERCENT = 2'd1,
		PH_HIGH = 2'd2
	} phase_t;

	phase_t phase_q, phase_n;
	logic [3:0] nibble_q, nibble_n;
	logic [15:0] count_q, count_n;
	urlpd_pkg::status_t fault_q, fault_n;
	logic fire;
	logic hex_ok;
	logic [3:0] hex_val;
	logic has_data;
	logic [7:0] data;

	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

	assign byte_stall = queue_full;
	assign fire = byte_valid && !byte_stall;
	assign {hex_ok, hex_val} = hex_decode(in_byte);

	always_comb begin
		phase_n = phase_q;
		nibble_n = nibble_q;
		fault_n = fault_q;
		has_data = 1'b0;
		data = in_byte;
		if (fault_q == urlpd_pkg::STATUS_OK) begin
			unique case (phase_q)
				PH_PERCENT: begin
					if (in_last) begin
						fault_n = urlpd_pkg::STATUS_TRUNC;
					end else if (!hex_ok) begin
						fault_n = urlpd_pkg::STATUS_BAD_HEX;
					end else begin
						nibble_n = hex_val;
						phase_n = PH_HIGH;
					end
				end
				PH_HIGH: begin
					if (!hex_ok) begin
						fault_n = urlpd_pkg::STATUS_BAD_HEX;
					end else begin
						has_data = 1'b1;
						data = {nibble_q, hex_val};
						phase_n = PH_IDLE;
					end
				end
				default: begin
					if (in_byte == urlpd_pkg::CH_PERCENT) begin
						if (in_last) begin
							fault_n = urlpd_pkg::STATUS_TRUNC;
						end else begin
							phase_n = PH_PERCENT;
						end
					end else if (in_byte == urlpd_pkg::CH_PLUS) begin
						has_data = 1'b1;
						data = urlpd_pkg::CH_SPACE;
					end else begin
						has_data = 1'b1;
					end
				end
			endcase
		end
		count_n = (has_data && count_q < urlpd_pkg::COUNT_CAP) ? count_q + 16'd1 : count_q;
	end

	always_comb begin
		push_entry.has_data = has_data;
		push_entry.data = data;
		push_entry.has_status = in_last;
		push_entry.code = fault_n;
		push_entry.length = (fault_n == urlpd_pkg::STATUS_OK) ? count_n : 16'd0;
	end

	assign push = fire && (has_data || in_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			nibble_q <= 4'd0;
			count_q <= 16'd0;
			fault_q <= urlpd_pkg::STATUS_OK;
		end else if (fire) begin
			if (in_last) begin
				phase_q <= PH_IDLE;
				nibble_q <= 4'd0;
				count_q <= 16'd0;
				fault_q <= urlpd_pkg::STATUS_OK;
			end else begin
				phase_q <= phase_n;
				nibble_q <= nibble_n;
				count_q <= count_n;
				fault_q <= fault_n;
			end
		end
	end

endmodule

FILE: design/urlpd_queue.sv
// Short entry queue between the front and back ends of the URL percent decoder.
// Depends on urlpd_pkg for the entry type.
module urlpd_queue #(
	parameter int unsigned DEPTH = urlpd_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input urlpd_pkg::entry_t push_entry,
	input logic pop,
	output urlpd_pkg::entry_t head,
	output logic empty,
	output logic full
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	urlpd_pkg::entry_t slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign empty = (count_q == '0);
	assign full = (count_q == CW'(DEPTH));
	assign head = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

FILE: design/urlpd_back.sv
// Back end of the URL percent decoder: turns queued entries into result transfers.
// Depends on urlpd_pkg; reads entries from urlpd_queue.
module urlpd_back (
	input logic clk,
	input logic arst_n,
	input urlpd_pkg::entry_t head,
	input logic empty,
	output logic pop,
	output logic result_valid,
	input logic result_stall,
	output logic is_status,
	output logic [7:0] data_byte,
	output logic [1:0] status_code,
	output logic [15:0] out_length,
	output logic run_last
);

	logic valid_q;
	logic sent_data_q;
	logic load;
	logic send_data;

	assign load = !empty && (!valid_q || !result_stall);
	assign send_data = head.has_data && !sent_data_q;
	assign pop = load && (!send_data || !head.has_status);
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sent_data_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sent_data_q <= send_data && head.has_status;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (send_data) begin
				is_status <= 1'b0;
				data_byte <= head.data;
				status_code <= urlpd_pkg::STATUS_OK;
				out_length <= 16'd0;
				run_last <= !head.has_status;
			end else begin
				is_status <= 1'b1;
				data_byte <= 8'd0;
				status_code <= head.code;
				out_length <= head.length;
				run_last <= 1'b1;
			end
		end
	end

endmodule

FILE: design/url_percent_decoder_unit.sv
// Top level of the streaming URL percent decoder.
// Depends on urlpd_pkg, assert_macros.svh, urlpd_front, urlpd_queue and urlpd_back.
//
// The input channel takes one byte of an encoded message per transfer, with in_last
// on the final byte. A '%' and two hex digits become one byte, '+' becomes a space,
// and other bytes pass unchanged. The output channel carries data records and, for
// the last byte of each message, a status record with the decoded length or an
// error code; run_last marks the final result caused by one input byte.
// The front end classifies one byte per cycle while the queue has room, into a queue
// of QUEUE_DEPTH entries, and the back end drains the queue into a registered output stage.
// The first result of a byte passes through the queue and then the output register.
// Sustained rate is one byte per cycle while the receiver does not stall; a last byte
// that also yields a data byte gives two results, sent one after the other by the single output register.
// Reset clears the escape state, the byte count, the queue and the output valid.
// When the receiver stalls, the output holds, the queue fills, and the input
// channel stalls once the queue is full.
`include "assert_macros.svh"

module url_percent_decoder_unit #(
	parameter int unsigned QUEUE_DEPTH = urlpd_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	output logic byte_stall,
	input logic [7:0] in_byte,
	input logic in_last,
	output logic result_valid,
	input logic result_stall,
	output logic is_status,
	output logic [7:0] data_byte,
	output logic [1:0] status_code,
	output logic [15:0] out_length,
	output logic run_last
);

	logic push;
	logic pop;
	logic empty;
	logic full;
	urlpd_pkg::entry_t push_entry;
	urlpd_pkg::entry_t head;

	urlpd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.in_byte(in_byte),
		.in_last(in_last),
		.queue_full(full),
		.push(push),
		.push_entry(push_entry)
	);

	urlpd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.head(head),
		.empty(empty),
		.full(full)
	);

	urlpd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.pop(pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.is_status(is_status),
		.data_byte(data_byte),
		.status_code(status_code),
		.out_length(out_length),
		.run_last(run_last)
	);

	`URLPD_ASSERT_IMP(a_pop_nonempty, clk, arst_n, pop, !empty)
	`URLPD_ASSERT_IMP(a_push_not_full, clk, arst_n, push, !full)
	`URLPD_ASSERT_IMP(a_status_form, clk, arst_n, result_valid && is_status, data_byte == 8'd0 && run_last && (status_code == urlpd_pkg::STATUS_OK || out_length == 16'd0))
	`URLPD_ASSERT_IMP(a_data_form, clk, arst_n, result_valid && !is_status, status_code == urlpd_pkg::STATUS_OK && out_length == 16'd0)

endmodule

FILE: test/url_percent_decoder_unit_tb.sv
// Self-checking testbench for url_percent_decoder_unit: directed and random messages
// run against a built-in decoder predictor, with bursty input and stalled output.
// Depends on urlpd_pkg and the design files under design.
module url_percent_decoder_unit_tb;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_LIMIT = 1000;
	localparam int RANDOM_BYTES = 2000;

	typedef enum logic [1:0] {
		ESC_IDLE = 2'd0,
		ESC_PERCENT = 2'd1,
		ESC_HIGH = 2'd2
	} esc_state_t;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PATTERN,
		STALL_HEAVY
	} stall_mode_t;

	typedef struct packed {
		logic is_status;
		logic [7:0] data;
		urlpd_pkg::status_t code;
		logic [15:0] length;
		logic run_last;
	} decoded_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic byte_valid;
	logic byte_stall;
	logic [7:0] in_byte;
	logic in_last;
	logic result_valid;
	logic result_stall;
	logic is_status;
	logic [7:0] data_byte;
	logic [1:0] status_code;
	logic [15:0] out_length;
	logic run_last;

	decoded_result_t pending_results[$];
	decoded_result_t head_result;

	esc_state_t esc_state;
	logic [3:0] esc_high;
	logic [15:0] msg_count;
	urlpd_pkg::status_t msg_fault;

	int mismatches = 0;
	int idle_cycles = 0;
	bit sender_bursty = 1'b0;
	int burst_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int stall_period = 4;
	int stall_duty = 1;
	int stall_tick = 0;

	url_percent_decoder_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.in_byte(in_byte),
		.in_last(in_last),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.is_status(is_status),
		.data_byte(data_byte),
		.status_code(status_code),
		.out_length(out_length),
		.run_last(run_last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] nib);
		nib = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			nib = 4'(c - 8'h30);
			return 1'b1;
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			nib = 4'(c - 8'h41 + 8'd10);
			return 1'b1;
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			nib = 4'(c - 8'h61 + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 4'd10)
			return 8'h30 + 8'(v);
		return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
	endfunction

	// Bytes that sit right next to the hex digit ranges, plus the high extremes.
	function automatic logic [7:0] edge_char();
		case ($urandom_range(0, 7))
			0: return 8'h2F;
			1: return 8'h3A;
			2: return 8'h40;
			3: return 8'h47;
			4: return 8'h60;
			5: return 8'h67;
			6: return 8'h80;
			default: return 8'hFF;
		endcase
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == urlpd_pkg::CH_PERCENT)
			b = 8'h26;
		return b;
	endfunction

	function automatic logic [7:0] noise_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return urlpd_pkg::CH_PERCENT;
		if (r < 6)
			return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
		if (r < 7)
			return edge_char();
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic clear_decoder_state();
		esc_state = ESC_IDLE;
		esc_high = 4'd0;
		msg_count = 16'd0;
		msg_fault = urlpd_pkg::STATUS_OK;
	endtask

	task automatic predict_decode(input logic [7:0] b, input logic last);
		logic [3:0] nib;
		bit have_data;
		logic [7:0] value;
		have_data = 1'b0;
		value = 8'd0;
		if (msg_fault == urlpd_pkg::STATUS_OK) begin
			case (esc_state)
				ESC_PERCENT: begin
					if (last)
						msg_fault = urlpd_pkg::STATUS_TRUNC;
					else if (!hex_digit(b, nib))
						msg_fault = urlpd_pkg::STATUS_BAD_HEX;
					else begin
						esc_high = nib;
						esc_state = ESC_HIGH;
					end
				end
				ESC_HIGH: begin
					if (!hex_digit(b, nib))
						msg_fault = urlpd_pkg::STATUS_BAD_HEX;
					else begin
						have_data = 1'b1;
						value = {esc_high, nib};
						esc_state = ESC_IDLE;
					end
				end
				default: begin
					if (b == urlpd_pkg::CH_PERCENT) begin
						if (last)
							msg_fault = urlpd_pkg::STATUS_TRUNC;
						else
							esc_state = ESC_PERCENT;
					end else begin
						have_data = 1'b1;
						value = (b == urlpd_pkg::CH_PLUS) ? urlpd_pkg::CH_SPACE : b;
					end
				end
			endcase
		end
		if (have_data) begin
			pending_results.push_back('{1'b0, value, urlpd_pkg::STATUS_OK, 16'd0, !last});
			if (msg_count < urlpd_pkg::COUNT_CAP)
				msg_count++;
		end
		if (last) begin
			pending_results.push_back('{1'b1, 8'd0, msg_fault,
				(msg_fault == urlpd_pkg::STATUS_OK) ? msg_count : 16'd0, 1'b1});
			clear_decoder_state();
		end
	endtask

	task automatic note_mismatch(input string what, input logic [15:0] want_v,
			input logic [15:0] got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %h, got %h", what, want_v, got_v);
	endtask

	task automatic check_field(input string what, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (got_v !== want_v)
			note_mismatch(what, want_v, got_v);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				note_mismatch("result with nothing pending (data_byte)", 16'd0, 16'(data_byte));
			end else begin
				head_result = pending_results.pop_front();
				check_field("is_status", 16'(head_result.is_status), 16'(is_status));
				check_field("data_byte", 16'(head_result.data), 16'(data_byte));
				check_field("status_code", 16'(head_result.code), 16'(status_code));
				check_field("out_length", head_result.length, out_length);
				check_field("run_last", 16'(head_result.run_last), 16'(run_last));
			end
		end
	end

	always @(posedge clk) begin
		stall_tick <= (stall_tick + 1) % stall_period;
		case (stall_mode)
			STALL_NONE: result_stall <= 1'b0;
			STALL_RANDOM: result_stall <= ($urandom_range(0, 99) < 35);
			STALL_PATTERN: result_stall <= (stall_tick < stall_duty);
			default: result_stall <= ($urandom_range(0, 99) < 85);
		endcase
	end

	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("url_percent_decoder_unit regression: fail");
			$finish;
		end
	end

	task automatic set_idling(input bit bursty, input stall_mode_t mode);
		sender_bursty = bursty;
		stall_mode = mode;
		stall_period = $urandom_range(2, 9);
		stall_duty = $urandom_range(1, stall_period - 1);
		burst_left = $urandom_range(1, 24);
	endtask

	task automatic random_idling();
		case ($urandom_range(0, 5))
			0: set_idling(1'b0, STALL_NONE);
			1: set_idling(1'b1, STALL_PATTERN);
			2: set_idling(1'b0, STALL_HEAVY);
			3: set_idling(1'b1, STALL_HEAVY);
			default: set_idling(1'b1, STALL_RANDOM);
		endcase
	endtask

	// Valid stays high after a transfer; the caller either sends again in the
	// same step or lowers it through a gap or a drain.
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (sender_bursty && burst_left <= 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		byte_valid <= 1'b1;
		in_byte <= b;
		in_last <= last;
		do
			@(posedge clk);
		while (byte_stall);
		predict_decode(b, last);
		burst_left--;
	endtask

	task automatic send_message(input logic [7:0] msg[$]);
		foreach (msg[i])
			send_byte(msg[i], i == msg.size() - 1);
	endtask

	task automatic wait_drain();
		int waited;
		byte_valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (16) @(posedge clk);
		if (pending_results.size() != 0) begin
			note_mismatch("results never produced (count)", 16'd0,
				16'(pending_results.size()));
			pending_results.delete();
		end
	endtask

	task automatic test_plain_and_plus();
		set_idling(1'b0, STALL_NONE);
		send_message('{8'h00, 8'hFF, urlpd_pkg::CH_PLUS, 8'h61});
	endtask

	task automatic test_escapes();
		set_idling(1'b1, STALL_RANDOM);
		send_message('{urlpd_pkg::CH_PERCENT, 8'h34, 8'h31, urlpd_pkg::CH_PERCENT,
			8'h66, 8'h46});
	endtask

	task automatic test_truncation();
		send_message('{urlpd_pkg::CH_PERCENT});
		send_message('{urlpd_pkg::CH_PERCENT, 8'h32});
	endtask

	task automatic test_bad_hex();
		set_idling(1'b0, STALL_HEAVY);
		send_message('{urlpd_pkg::CH_PERCENT, 8'h47, 8'h78});
		send_message('{urlpd_pkg::CH_PERCENT, 8'h34, 8'h7A});
		send_message('{urlpd_pkg::CH_PERCENT, 8'hFF, 8'h61});
	endtask

	task automatic test_random_messages();
		logic [7:0] msg[$];
		int sent;
		int kind;
		int pick;
		sent = 0;
		random_idling();
		while (sent < RANDOM_BYTES) begin
			if ($urandom_range(0, 19) == 0)
				random_idling();
			msg = {};
			kind = $urandom_range(0, 99);
			if (kind < 15) begin
				repeat ($urandom_range(1, 10))
					msg.push_back(noise_char());
			end else begin
				repeat ($urandom_range(1, 6)) begin
					pick = $urandom_range(0, 9);
					if (pick < 4) begin
						msg.push_back(urlpd_pkg::CH_PERCENT);
						msg.push_back(hex_char(4'($urandom_range(0, 15)),
							1'($urandom_range(0, 1))));
						msg.push_back(hex_char(4'($urandom_range(0, 15)),
							1'($urandom_range(0, 1))));
					end else if (pick < 5) begin
						msg.push_back(urlpd_pkg::CH_PLUS);
					end else begin
						msg.push_back(plain_char());
					end
				end
				// Broken sequences: cut the tail or damage one byte.
				if (kind >= 85) begin
					if ($urandom_range(0, 1) == 0) begin
						repeat ($urandom_range(1, 2))
							if (msg.size() > 1)
								void'(msg.pop_back());
					end else begin
						msg[$urandom_range(0, msg.size() - 1)] = noise_char();
					end
				end
			end
			send_message(msg);
			sent += msg.size();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		byte_valid <= 1'b0;
		in_byte <= 8'd0;
		in_last <= 1'b0;
		result_stall <= 1'b0;
		clear_decoder_state();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_and_plus();
		test_escapes();
		test_truncation();
		test_bad_hex();
		test_random_messages();
		wait_drain();
		if (mismatches == 0)
			$display("url_percent_decoder_unit regression: pass");
		else
			$display("url_percent_decoder_unit regression: fail");
		$finish;
	end

endmodule
